// ===== rtl/nmea_pkg.sv =====
// Package for the NMEA position sentence parser: character codes, field
// numbers, sentence kinds and the packed result layout.
// No dependencies.
package nmea_pkg;

    // Framing and separator characters
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_SYNC   = 8'hB5;
    localparam logic [7:0] CHAR_ABORT  = 8'hFF;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    // Address prefixes: "PUB" and "GNRM"
    localparam logic [23:0] PREFIX_PUBX = 24'h505542;
    localparam logic [31:0] PREFIX_GNRM = 32'h474E524D;

    // Sentence length limit and coordinate characters kept
    localparam logic [7:0] MAX_SENTENCE_LEN = 8'd128;
    localparam logic [7:0] COUNT_MAX        = 8'd255;
    localparam logic [3:0] COORD_CHARS      = 4'd10;
    localparam logic [3:0] FIELD_CHAR_MAX   = 4'd15;

    // Accuracy defaults and limit
    localparam logic [19:0] ACC_DEFAULT = 20'd99999;
    localparam logic [19:0] ACC_MAX     = 20'hFFFFF;

    // Field numbers, counted by commas from the address field
    localparam logic [7:0] FIELD_TIME = 8'd1;
    localparam logic [7:0] FIELD_LAT  = 8'd3;
    localparam logic [7:0] FIELD_NS   = 8'd4;
    localparam logic [7:0] FIELD_LON  = 8'd5;
    localparam logic [7:0] FIELD_EW   = 8'd6;
    localparam logic [7:0] FIELD_ACC  = 8'd9;

    // Sentence kinds
    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_PUBX  = 2'd1;
    localparam logic [1:0] KIND_GNRM  = 2'd2;

    typedef logic [9:0][7:0] coord_t;
    typedef logic [3:0][7:0] time_t;
    typedef logic [5:0][7:0] date_t;

    // Result layout, last field in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [47:0] date_chars;
        logic [31:0] time_chars;
        logic [19:0] accuracy;
        logic [7:0]  east_west;
        logic [7:0]  north_south;
        logic [39:0] lon_tail;
        logic [39:0] lon_head;
        logic [39:0] lat_tail;
        logic [39:0] lat_head;
        logic [1:0]  sentence_kind;
    } result_t;

endpackage

// ===== rtl/nmea_position_sentence_parser.sv =====
// Top level of the NMEA position sentence parser: byte framing, field capture
// and the result register with a skid stage.
// Depends on nmea_pkg.
//
// Channel  Dir  Width  Contents
// s_       in   8      rx_byte
// m_       out  280    sentence_kind, lat/lon head and tail, hemispheres,
//                      accuracy, time_chars, date_chars
//
// One byte is taken per cycle; each byte updates the parse registers in the
// cycle it is accepted, and the second checksum byte loads the result register,
// so a result is valid on the cycle after that byte. A result that meets a
// stalled output waits in the skid register; input stalls only while the skid
// register is full. aresetn (synchronous, active low) returns to idle and
// drops any pending result.
module nmea_position_sentence_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [279:0] m_tdata    // [1:0] sentence_kind, [41:2] lat_head,
                                    // [81:42] lat_tail, [121:82] lon_head,
                                    // [161:122] lon_tail, [169:162] north_south,
                                    // [177:170] east_west, [197:178] accuracy,
                                    // [229:198] time_chars, [277:230] date_chars
);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_BODY,
        MODE_SKIP,
        MODE_TAIL
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [7:0]          byte_count_reg, byte_count_next;
    logic                tail_second_reg, tail_second_next;
    logic [31:0]         prefix_reg, prefix_next;
    logic [7:0]          comma_count_reg, comma_count_next;
    logic [3:0]          char_idx_reg, char_idx_next;
    nmea_pkg::coord_t    lat_reg, lat_next;
    nmea_pkg::coord_t    lon_reg, lon_next;
    logic [7:0]          ns_reg, ns_next;
    logic [7:0]          ew_reg, ew_next;
    logic [19:0]         acc_reg, acc_next;
    logic                acc_done_reg, acc_done_next;
    nmea_pkg::time_t     time_reg, time_next;
    nmea_pkg::date_t     date_reg, date_next;

    logic                out_valid_reg, out_valid_next;
    nmea_pkg::result_t   out_reg, out_next;
    logic                skid_valid_reg, skid_valid_next;
    nmea_pkg::result_t   skid_reg, skid_next;

    logic                in_fire;
    logic                result_fire;
    logic [23:0]         acc_sum;
    nmea_pkg::result_t   result;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Accuracy digit step: times ten plus the digit value
    assign acc_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {20'd0, s_tdata[3:0]};

    // Build the result from the captured fields
    always_comb begin
        result = '0;
        result.accuracy = nmea_pkg::ACC_DEFAULT;
        if (prefix_reg[31:8] == nmea_pkg::PREFIX_PUBX) begin
            result.sentence_kind = nmea_pkg::KIND_PUBX;
            result.lat_head    = {lat_reg[0], lat_reg[1], lat_reg[2], lat_reg[3], lat_reg[4]};
            result.lat_tail    = {lat_reg[5], lat_reg[6], lat_reg[7], lat_reg[8], lat_reg[9]};
            result.lon_head    = {lon_reg[0], lon_reg[1], lon_reg[2], lon_reg[3], lon_reg[4]};
            result.lon_tail    = {lon_reg[5], lon_reg[6], lon_reg[7], lon_reg[8], lon_reg[9]};
            result.north_south = ns_reg;
            result.east_west   = ew_reg;
            if (comma_count_reg >= nmea_pkg::FIELD_ACC) begin
                result.accuracy = acc_reg;
            end
        end else if (prefix_reg == nmea_pkg::PREFIX_GNRM) begin
            result.sentence_kind = nmea_pkg::KIND_GNRM;
            result.time_chars = {time_reg[0], time_reg[1], time_reg[2], time_reg[3]};
            result.date_chars = {date_reg[0], date_reg[1], date_reg[2],
                                 date_reg[3], date_reg[4], date_reg[5]};
        end
    end

    // Parse one accepted byte
    always_comb begin
        mode_next        = mode_reg;
        byte_count_next  = byte_count_reg;
        tail_second_next = tail_second_reg;
        prefix_next      = prefix_reg;
        comma_count_next = comma_count_reg;
        char_idx_next    = char_idx_reg;
        lat_next         = lat_reg;
        lon_next         = lon_reg;
        ns_next          = ns_reg;
        ew_next          = ew_reg;
        acc_next         = acc_reg;
        acc_done_next    = acc_done_reg;
        time_next        = time_reg;
        date_next        = date_reg;
        result_fire      = 1'b0;

        if (in_fire) begin
            unique case (mode_reg)
                MODE_IDLE: begin
                    if (s_tdata == nmea_pkg::CHAR_DOLLAR) begin
                        // Start a sentence: clear everything captured
                        mode_next        = MODE_BODY;
                        byte_count_next  = '0;
                        tail_second_next = 1'b0;
                        prefix_next      = '0;
                        comma_count_next = '0;
                        char_idx_next    = '0;
                        lat_next         = '0;
                        lon_next         = '0;
                        ns_next          = '0;
                        ew_next          = '0;
                        acc_next         = '0;
                        acc_done_next    = 1'b0;
                        time_next        = '0;
                        date_next        = '0;
                    end else if (s_tdata == nmea_pkg::CHAR_SYNC) begin
                        mode_next       = MODE_SKIP;
                        byte_count_next = '0;
                    end
                end
                MODE_SKIP: begin
                    // Drop binary bytes until abort or length limit
                    if (s_tdata == nmea_pkg::CHAR_ABORT ||
                        byte_count_reg >= nmea_pkg::MAX_SENTENCE_LEN) begin
                        mode_next = MODE_IDLE;
                    end else if (byte_count_reg != nmea_pkg::COUNT_MAX) begin
                        byte_count_next = byte_count_reg + 8'd1;
                    end
                end
                MODE_BODY: begin
                    if (s_tdata == nmea_pkg::CHAR_ABORT ||
                        byte_count_reg >= nmea_pkg::MAX_SENTENCE_LEN) begin
                        mode_next = MODE_IDLE;
                    end else if (s_tdata == nmea_pkg::CHAR_STAR) begin
                        mode_next        = MODE_TAIL;
                        tail_second_next = 1'b0;
                    end else begin
                        // Keep the first four body characters
                        if (byte_count_reg < 8'd4) begin
                            case (byte_count_reg[1:0])
                                2'd0:    prefix_next[31:24] = s_tdata;
                                2'd1:    prefix_next[23:16] = s_tdata;
                                2'd2:    prefix_next[15:8]  = s_tdata;
                                default: prefix_next[7:0]   = s_tdata;
                            endcase
                        end
                        if (s_tdata == nmea_pkg::CHAR_COMMA) begin
                            if (comma_count_reg != nmea_pkg::COUNT_MAX) begin
                                comma_count_next = comma_count_reg + 8'd1;
                            end
                            char_idx_next = '0;
                        end else begin
                            // Capture characters of the fields of interest
                            case (comma_count_reg)
                                nmea_pkg::FIELD_TIME: begin
                                    if (char_idx_reg < 4'd4) begin
                                        time_next[char_idx_reg[1:0]] = s_tdata;
                                    end
                                end
                                nmea_pkg::FIELD_LAT: begin
                                    if (char_idx_reg < nmea_pkg::COORD_CHARS) begin
                                        lat_next[char_idx_reg] = s_tdata;
                                    end
                                end
                                nmea_pkg::FIELD_NS: begin
                                    if (char_idx_reg == 4'd0) begin
                                        ns_next = s_tdata;
                                    end
                                end
                                nmea_pkg::FIELD_LON: begin
                                    if (char_idx_reg < nmea_pkg::COORD_CHARS) begin
                                        lon_next[char_idx_reg] = s_tdata;
                                    end
                                end
                                nmea_pkg::FIELD_EW: begin
                                    if (char_idx_reg == 4'd0) begin
                                        ew_next = s_tdata;
                                    end
                                end
                                nmea_pkg::FIELD_ACC: begin
                                    if (char_idx_reg < 4'd6) begin
                                        date_next[char_idx_reg[2:0]] = s_tdata;
                                    end
                                    if (!acc_done_reg) begin
                                        if (s_tdata >= nmea_pkg::CHAR_ZERO &&
                                            s_tdata <= nmea_pkg::CHAR_NINE) begin
                                            if (acc_sum > {4'd0, nmea_pkg::ACC_MAX}) begin
                                                acc_next = nmea_pkg::ACC_MAX;
                                            end else begin
                                                acc_next = acc_sum[19:0];
                                            end
                                        end else begin
                                            acc_done_next = 1'b1;
                                        end
                                    end
                                end
                                default: begin
                                end
                            endcase
                            if (char_idx_reg != nmea_pkg::FIELD_CHAR_MAX) begin
                                char_idx_next = char_idx_reg + 4'd1;
                            end
                        end
                        if (byte_count_reg != nmea_pkg::COUNT_MAX) begin
                            byte_count_next = byte_count_reg + 8'd1;
                        end
                    end
                end
                MODE_TAIL: begin
                    // Consume two checksum bytes, emit on the second
                    if (!tail_second_reg) begin
                        tail_second_next = 1'b1;
                    end else begin
                        tail_second_next = 1'b0;
                        mode_next        = MODE_IDLE;
                        result_fire      = 1'b1;
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end
    end

    // Output register with skid stage
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (out_valid_reg && !m_tready) begin
            if (result_fire) begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_next        = skid_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end else begin
            out_next       = result;
            out_valid_next = result_fire;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            byte_count_reg  <= '0;
            tail_second_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            mode_reg        <= mode_next;
            byte_count_reg  <= byte_count_next;
            tail_second_reg <= tail_second_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
        prefix_reg      <= prefix_next;
        comma_count_reg <= comma_count_next;
        char_idx_reg    <= char_idx_next;
        lat_reg         <= lat_next;
        lon_reg         <= lon_next;
        ns_reg          <= ns_next;
        ew_reg          <= ew_next;
        acc_reg         <= acc_next;
        acc_done_reg    <= acc_done_next;
        time_reg        <= time_next;
        date_reg        <= date_next;
        out_reg         <= out_next;
        skid_reg        <= skid_next;
    end

endmodule
